/* sv/tplb_pkg.sv */
// ----------------------------------------------------------------------------
// tplb_pkg: shared types and constants for the threshold promote LRU buffer
// Sizes, input item and result item layouts used by the top level and the
// slot store.
// ----------------------------------------------------------------------------
package tplb_pkg;

    // Buffer depth and stored key width
    localparam int ENTRIES   = 4;
    localparam int KEY_WIDTH = 32;

    // Port field widths
    localparam int KEY_PORT_W = 32;
    localparam int COUNT_W    = 8;
    localparam int POS_W      = 6;
    localparam int THR_W      = 8;

    // Derived widths
    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OCC_W = $clog2(ENTRIES + 1);

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // Item kinds
    localparam logic KIND_ACCESS = 1'b0;
    localparam logic KIND_CLEAR  = 1'b1;

    typedef struct packed {
        logic                  kind;
        logic [KEY_PORT_W-1:0] key;
    } item_t;

    typedef struct packed {
        logic                  hit;
        logic [COUNT_W-1:0]    use_count;
        logic [POS_W-1:0]      position;
        logic                  promoted;
        logic                  evicted;
        logic [KEY_PORT_W-1:0] evicted_key;
    } result_t;

endpackage

/* sv/tplb_slots.sv */
// ----------------------------------------------------------------------------
// tplb_slots: slot store with lookup, promote and insert
// Holds the ordered keys and use counts, compares all valid slots against
// the key combinationally, and applies the shift for an insert or a promote.
// ----------------------------------------------------------------------------
module tplb_slots
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                step,
    input  tplb_pkg::item_t                     item,
    input  logic [tplb_pkg::THR_W-1:0]          threshold,
    output tplb_pkg::result_t                   res
);

    logic [tplb_pkg::KEY_WIDTH-1:0] slot_key_reg   [tplb_pkg::ENTRIES];
    logic [tplb_pkg::KEY_WIDTH-1:0] slot_key_next  [tplb_pkg::ENTRIES];
    logic [tplb_pkg::COUNT_W-1:0]   slot_count_reg [tplb_pkg::ENTRIES];
    logic [tplb_pkg::COUNT_W-1:0]   slot_count_next[tplb_pkg::ENTRIES];
    logic [tplb_pkg::OCC_W-1:0]     occ_reg;
    logic [tplb_pkg::OCC_W-1:0]     occ_next;

    logic [tplb_pkg::KEY_WIDTH-1:0] key_cmp;
    logic [tplb_pkg::ENTRIES-1:0]   match;
    logic [tplb_pkg::ENTRIES-1:0]   first;
    logic [tplb_pkg::IDX_W-1:0]     hit_idx;
    logic                           found;
    logic [tplb_pkg::COUNT_W-1:0]   old_count;
    logic [tplb_pkg::COUNT_W-1:0]   new_count;
    logic                           promote;
    logic                           full;

    assign key_cmp = item.key[tplb_pkg::KEY_WIDTH-1:0];
    assign full    = (occ_reg == tplb_pkg::OCC_W'(tplb_pkg::ENTRIES));

    // Compare the key against every valid slot
    always_comb
    begin
        for (int i = 0; i < tplb_pkg::ENTRIES; i++)
        begin
            match[i] = (tplb_pkg::OCC_W'(i) < occ_reg) && (slot_key_reg[i] == key_cmp);
        end
    end

    // Pick the frontmost match and select its count
    always_comb
    begin
        first     = '0;
        hit_idx   = '0;
        old_count = '0;
        for (int i = tplb_pkg::ENTRIES - 1; i >= 0; i--)
        begin
            if (match[i])
            begin
                first   = '0;
                first[i] = 1'b1;
                hit_idx = tplb_pkg::IDX_W'(i);
            end
        end
        for (int i = 0; i < tplb_pkg::ENTRIES; i++)
        begin
            if (first[i])
            begin
                old_count = slot_count_reg[i];
            end
        end
    end

    assign found     = |match;
    assign new_count = (old_count == tplb_pkg::COUNT_MAX) ? old_count
                                                          : old_count + tplb_pkg::COUNT_W'(1);
    assign promote   = found && (new_count > threshold) && (hit_idx != '0);

    // Build the next slot contents
    always_comb
    begin
        occ_next = occ_reg;
        for (int i = 0; i < tplb_pkg::ENTRIES; i++)
        begin
            slot_key_next[i]   = slot_key_reg[i];
            slot_count_next[i] = slot_count_reg[i];
        end
        if (step)
        begin
            if (item.kind == tplb_pkg::KIND_CLEAR)
            begin
                occ_next = '0;
            end
            else if (!found)
            begin
                // Insert at the front, shift everything back, drop the tail
                for (int i = 1; i < tplb_pkg::ENTRIES; i++)
                begin
                    slot_key_next[i]   = slot_key_reg[i-1];
                    slot_count_next[i] = slot_count_reg[i-1];
                end
                slot_key_next[0]   = key_cmp;
                slot_count_next[0] = tplb_pkg::COUNT_W'(1);
                if (!full)
                begin
                    occ_next = occ_reg + tplb_pkg::OCC_W'(1);
                end
            end
            else if (promote)
            begin
                // Move the hit entry to the front, shift the ones ahead of it
                for (int i = 1; i < tplb_pkg::ENTRIES; i++)
                begin
                    if (tplb_pkg::IDX_W'(i) <= hit_idx)
                    begin
                        slot_key_next[i]   = slot_key_reg[i-1];
                        slot_count_next[i] = slot_count_reg[i-1];
                    end
                end
                slot_key_next[0]   = key_cmp;
                slot_count_next[0] = new_count;
            end
            else
            begin
                for (int i = 0; i < tplb_pkg::ENTRIES; i++)
                begin
                    if (first[i])
                    begin
                        slot_count_next[i] = new_count;
                    end
                end
            end
        end
    end

    // Form the result of this step
    always_comb
    begin
        res = '0;
        if (item.kind == tplb_pkg::KIND_ACCESS)
        begin
            if (found)
            begin
                res.hit       = 1'b1;
                res.use_count = new_count;
                res.position  = promote ? '0 : tplb_pkg::POS_W'(hit_idx);
                res.promoted  = promote;
            end
            else
            begin
                res.use_count = tplb_pkg::COUNT_W'(1);
                res.evicted   = full;
                res.evicted_key = full
                    ? tplb_pkg::KEY_PORT_W'(slot_key_reg[tplb_pkg::ENTRIES-1]) : '0;
            end
        end
    end

    // Hold slot payload, no reset needed
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < tplb_pkg::ENTRIES; i++)
        begin
            slot_key_reg[i]   <= slot_key_next[i];
            slot_count_reg[i] <= slot_count_next[i];
        end
    end

    // Track occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= tplb_pkg::OCC_W'(tplb_pkg::ENTRIES))
        else $error("occupancy exceeds buffer depth");

    a_keys_unique: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(match))
        else $error("key stored in more than one valid slot");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        step && (item.kind == tplb_pkg::KIND_CLEAR) |=> occ_reg == '0)
        else $error("clear did not empty the buffer");

    a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
        step && res.evicted |=> occ_reg == tplb_pkg::OCC_W'(tplb_pkg::ENTRIES))
        else $error("eviction left the buffer not full");

endmodule

/* sv/threshold_promote_lru_buffer.sv */
// ----------------------------------------------------------------------------
// threshold_promote_lru_buffer: move-to-front buffer with a hit threshold
// Looks up each key, inserts misses at the front with eviction from the back,
// and moves hit entries to the front once their count passes the threshold.
//
//   Channel   Handshake              Payload
//   -------   --------------------   --------------------------------------
//   input     in_valid / in_ready    kind, key
//   output    out_valid / out_ready  hit, use_count, position, promoted,
//                                    evicted, evicted_key
//   config    cfg_we                 cfg_wdata (promote_threshold)
//
// One item per cycle sustained while the output is not stalled; a result
// passes the input register, then lookup and update into the result
// register, before it is presented at the output.
// The slot update happens as the item leaves the input register.
// Reset empties the buffer and sets the threshold to 5; no clearing pass.
// A stalled output holds the result register and then the input register.
// ----------------------------------------------------------------------------
module threshold_promote_lru_buffer
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [tplb_pkg::THR_W-1:0]           cfg_wdata,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 kind,
    input  logic [tplb_pkg::KEY_PORT_W-1:0]      key,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 hit,
    output logic [tplb_pkg::COUNT_W-1:0]         use_count,
    output logic [tplb_pkg::POS_W-1:0]           position,
    output logic                                 promoted,
    output logic                                 evicted,
    output logic [tplb_pkg::KEY_PORT_W-1:0]      evicted_key
);

    logic [tplb_pkg::THR_W-1:0] thr_reg;
    logic                       in_valid_reg;
    tplb_pkg::item_t            in_item_reg;
    logic                       out_valid_reg;
    tplb_pkg::result_t          res_reg;
    tplb_pkg::result_t          res_next;
    logic                       advance;

    // Move the held item on when the result register is free
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    // Hold the threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= tplb_pkg::THR_W'(5);
        end
        else if (cfg_we)
        begin
            thr_reg <= cfg_wdata;
        end
    end

    // Capture an input transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_item_reg.kind <= kind;
            in_item_reg.key  <= key;
        end
    end

    tplb_slots u_slots
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .item      (in_item_reg),
        .threshold (thr_reg),
        .res       (res_next)
    );

    // Load the result register, drop it after an output transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign hit         = res_reg.hit;
    assign use_count   = res_reg.use_count;
    assign position    = res_reg.position;
    assign promoted    = res_reg.promoted;
    assign evicted     = res_reg.evicted;
    assign evicted_key = res_reg.evicted_key;

endmodule

/* test/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for threshold_promote_lru_buffer
// Drives lookups and clears through the valid/ready input, predicts every
// result with an independent move-to-front model, and compares each field
// of every result. Runs through several promote thresholds, including both
// extremes, with bursty input, a stalling receiver and long output hold-offs.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 4;
    localparam int HOLD_CYCLES  = 50;

    localparam logic [tplb_pkg::KEY_PORT_W-1:0] KEY_MASK =
        (tplb_pkg::KEY_WIDTH >= tplb_pkg::KEY_PORT_W)
            ? {tplb_pkg::KEY_PORT_W{1'b1}}
            : tplb_pkg::KEY_PORT_W'((64'd1 << tplb_pkg::KEY_WIDTH) - 64'd1);

    // Lookup buffer predictor plus store of pending expected results
    class lru_scoreboard;
        logic [tplb_pkg::KEY_PORT_W-1:0] slot_key [tplb_pkg::ENTRIES];
        logic [tplb_pkg::COUNT_W-1:0]    slot_count [tplb_pkg::ENTRIES];
        int                              occ;
        logic [tplb_pkg::THR_W-1:0]      threshold;
        tplb_pkg::result_t               expected_q[$];
        int errors, n_checked, n_hits, n_promotions, n_evictions, n_clears;

        function new();
            occ       = 0;
            threshold = tplb_pkg::THR_W'(5);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Apply one accepted item to the model and queue its result
        function void note_input(logic item_kind,
                                 logic [tplb_pkg::KEY_PORT_W-1:0] item_key);
            tplb_pkg::result_t               r;
            logic [tplb_pkg::KEY_PORT_W-1:0] kv;
            logic [tplb_pkg::COUNT_W-1:0]    cnt;
            int                              idx;
            int                              last;
            int                              i;
            r   = '0;
            kv  = item_key & KEY_MASK;
            idx = -1;
            if (item_kind == tplb_pkg::KIND_CLEAR) begin
                occ = 0;
                n_clears++;
            end
            else begin
                for (i = 0; i < occ; i++)
                    if (idx < 0 && slot_key[i] == kv)
                        idx = i;
                if (idx >= 0) begin
                    // hit: bump count, promote once above threshold
                    r.hit = 1'b1;
                    cnt = slot_count[idx];
                    if (cnt != tplb_pkg::COUNT_MAX)
                        cnt = cnt + tplb_pkg::COUNT_W'(1);
                    slot_count[idx] = cnt;
                    if (cnt > threshold && idx > 0) begin
                        for (i = idx; i > 0; i--) begin
                            slot_key[i]   = slot_key[i-1];
                            slot_count[i] = slot_count[i-1];
                        end
                        slot_key[0]   = kv;
                        slot_count[0] = cnt;
                        idx = 0;
                        r.promoted = 1'b1;
                        n_promotions++;
                    end
                    r.use_count = cnt;
                    r.position  = tplb_pkg::POS_W'(idx);
                    n_hits++;
                end
                else begin
                    // miss: insert at front, drop back entry when full
                    last = occ;
                    if (occ >= tplb_pkg::ENTRIES) begin
                        r.evicted     = 1'b1;
                        r.evicted_key = slot_key[tplb_pkg::ENTRIES-1];
                        last = tplb_pkg::ENTRIES - 1;
                        n_evictions++;
                    end
                    else begin
                        occ++;
                    end
                    for (i = last; i > 0; i--) begin
                        slot_key[i]   = slot_key[i-1];
                        slot_count[i] = slot_count[i-1];
                    end
                    slot_key[0]   = kv;
                    slot_count[0] = tplb_pkg::COUNT_W'(1);
                    r.use_count   = tplb_pkg::COUNT_W'(1);
                    r.position    = '0;
                end
            end
            expected_q.push_back(r);
        endfunction

        function void diff_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        // Compare one transferred result with the oldest expectation
        function void check_result(tplb_pkg::result_t got);
            tplb_pkg::result_t want;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %0h", $time, got);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            n_checked++;
            diff_field("hit",         32'(want.hit),         32'(got.hit));
            diff_field("use_count",   32'(want.use_count),   32'(got.use_count));
            diff_field("position",    32'(want.position),    32'(got.position));
            diff_field("promoted",    32'(want.promoted),    32'(got.promoted));
            diff_field("evicted",     32'(want.evicted),     32'(got.evicted));
            diff_field("evicted_key", 32'(want.evicted_key), 32'(got.evicted_key));
        endfunction
    endclass

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_we;
    logic [tplb_pkg::THR_W-1:0]      cfg_wdata;
    logic                            in_valid;
    logic                            in_ready;
    logic                            kind;
    logic [tplb_pkg::KEY_PORT_W-1:0] key;
    logic                            out_valid;
    logic                            out_ready;
    logic                            hit;
    logic [tplb_pkg::COUNT_W-1:0]    use_count;
    logic [tplb_pkg::POS_W-1:0]      position;
    logic                            promoted;
    logic                            evicted;
    logic [tplb_pkg::KEY_PORT_W-1:0] evicted_key;

    lru_scoreboard                   sb = new();
    int                              cycle_count;
    int                              burst_left;
    int                              n_settings;
    logic [tplb_pkg::KEY_PORT_W-1:0] key_pool [8];
    int                              pool_size;

    threshold_promote_lru_buffer DUT
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .key         (key),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .hit         (hit),
        .use_count   (use_count),
        .position    (position),
        .promoted    (promoted),
        .evicted     (evicted),
        .evicted_key (evicted_key)
    );

    // 10 ns clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog on total run length
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Check every output transfer
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result({hit, use_count, position, promoted, evicted, evicted_key});
    end

    // Receiver: drive ready on a changing stall pattern, with long hold-offs
    initial
    begin : receiver
        int mode;
        int mode_left;
        int hold_left;
        int holds_done;
        mode       = 0;
        mode_left  = 0;
        hold_left  = 0;
        holds_done = 0;
        out_ready  = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_left == 0 && holds_done < 2 && sb.n_checked >= 150 + 300 * holds_done) begin
                hold_left = HOLD_CYCLES;
                holds_done++;
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(10, 60);
            end
            mode_left--;
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else begin
                case (mode)
                    0: out_ready <= 1'b1;
                    1: out_ready <= ($urandom_range(0, 3) != 0);
                    2: out_ready <= ($urandom_range(0, 2) == 0);
                    default: out_ready <= ~out_ready;
                endcase
            end
        end
    end

    // Offer one item, holding it until transfer; bursts separated by gaps
    task automatic send_item(input logic item_kind,
                             input logic [tplb_pkg::KEY_PORT_W-1:0] item_key);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            repeat (gap) begin
                @(negedge clk);
                in_valid <= 1'b0;
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        @(negedge clk);
        in_valid <= 1'b1;
        kind     <= item_kind;
        key      <= item_key;
        do @(posedge clk); while (!in_ready);
        sb.note_input(item_kind, item_key);
    endtask

    task automatic access(input logic [tplb_pkg::KEY_PORT_W-1:0] item_key);
        send_item(tplb_pkg::KIND_ACCESS, item_key);
    endtask

    // Drop valid and wait until all results are back
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_threshold(input logic [tplb_pkg::THR_W-1:0] value);
        wait_idle();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        sb.threshold = value;
        n_settings++;
    endtask

    function automatic logic [tplb_pkg::KEY_PORT_W-1:0] pick_key();
        return key_pool[$urandom_range(0, pool_size - 1)];
    endfunction

    // Random phase: mostly keys from a small pool so hits and evictions mix
    task automatic random_phase(input logic [tplb_pkg::THR_W-1:0] value, input int count);
        int i;
        int roll;
        set_threshold(value);
        pool_size = $urandom_range(3, 7);
        for (i = 0; i < pool_size; i++)
            key_pool[i] = $urandom();
        for (i = 0; i < count; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < 4)
                send_item(tplb_pkg::KIND_CLEAR, $urandom());
            else if (roll < 12)
                access($urandom());
            else
                access(pick_key());
        end
    endtask

    initial
    begin : stimulus
        int i;
        logic [tplb_pkg::KEY_PORT_W-1:0] hot_key;
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_wdata   = '0;
        in_valid    = 1'b0;
        kind        = tplb_pkg::KIND_ACCESS;
        key         = '0;
        cycle_count = 0;
        burst_left  = 0;
        n_settings  = 1;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // Reset threshold: fill, hit below and above it, evict, clear
        access(32'h0000_0000);
        access(32'hFFFF_FFFF);
        repeat (5) access(32'h0000_0000);
        access(32'h0000_0000);
        access(32'h1234_5678);
        access(32'hA5A5_A5A5);
        access(32'h5A5A_5A5A);
        send_item(tplb_pkg::KIND_CLEAR, 32'hDEAD_BEEF);
        access(32'h0000_0000);
        send_item(tplb_pkg::KIND_CLEAR, 32'h0000_0000);

        // Threshold zero: every hit behind the front promotes
        set_threshold(tplb_pkg::THR_W'(0));
        access(32'h8000_0000);
        access(32'h0000_0001);
        access(32'h7FFF_FFFF);
        access(32'h8000_0000);
        access(32'h8000_0000);
        access(32'h0000_0001);
        access(32'hFFFF_FFFE);
        access(32'h0000_FFFF);

        // Highest threshold: drive one key's count into saturation
        set_threshold(tplb_pkg::THR_W'(255));
        hot_key     = $urandom();
        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hFFFF_FFFF;
        pool_size   = 2;
        send_item(tplb_pkg::KIND_CLEAR, '0);
        for (i = 0; i < 300; i++) begin
            if ($urandom_range(0, 99) < 92)
                access(hot_key);
            else
                access(pick_key());
        end

        // Saturated count now passes the threshold
        set_threshold(tplb_pkg::THR_W'(254));
        key_pool[2] = hot_key;
        pool_size   = 3;
        for (i = 0; i < 20; i++)
            access(pick_key());

        random_phase(tplb_pkg::THR_W'(1), 60);
        random_phase(tplb_pkg::THR_W'(2), 60);
        random_phase(tplb_pkg::THR_W'(0), 60);
        random_phase(tplb_pkg::THR_W'(255), 60);
        random_phase(tplb_pkg::THR_W'($urandom_range(0, 255)), 60);
        random_phase(tplb_pkg::THR_W'(5), 60);
        random_phase(tplb_pkg::THR_W'($urandom_range(0, 8)), 60);

        wait_idle();
        $display("Checked %0d results in %0d cycles over %0d threshold settings",
                 sb.n_checked, cycle_count, n_settings);
        $display("Saw %0d hits, %0d promotions, %0d evictions, %0d clears",
                 sb.n_hits, sb.n_promotions, sb.n_evictions, sb.n_clears);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* filelist.f */
sv/tplb_pkg.sv
sv/tplb_slots.sv
sv/threshold_promote_lru_buffer.sv
test/tb_top.sv
